>>> design/plm_pkg.sv
`default_nettype none

package plm_pkg;

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;
    localparam int PEAK_W     = 31;
    localparam int LEVEL_W    = 7;
    localparam int PROD_W     = 63;

    typedef enum logic [1:0] {
        WIDTH_8  = 2'd0,
        WIDTH_16 = 2'd1,
        WIDTH_24 = 2'd2,
        WIDTH_32 = 2'd3
    } t_width_mode;

    typedef enum logic [1:0] {
        REG_WIDTH  = 2'd0,
        REG_STEREO = 2'd1,
        REG_ENDIAN = 2'd2,
        REG_THRESH = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [31:0] sample_word;
        logic        last_sample;
    } t_plm_in;

    typedef struct packed {
        logic [LEVEL_W-1:0] level_left;
        logic [LEVEL_W-1:0] level_right;
        logic [PEAK_W-1:0]  peak_left;
        logic [PEAK_W-1:0]  peak_right;
        logic               loud_event;
    } t_plm_out;

    typedef struct packed {
        t_width_mode        width_mode;
        logic               stereo;
        logic               big_endian;
        logic [LEVEL_W-1:0] threshold;
    } t_plm_cfg;

    typedef struct packed {
        logic [PEAK_W-1:0] peak_left;
        logic [PEAK_W-1:0] peak_right;
    } t_plm_peaks;

    localparam logic [LEVEL_W-1:0] THRESH_RESET = 7'd50;
    localparam logic [LEVEL_W-1:0] LEVEL_MAX    = 7'd100;
    localparam logic [PEAK_W-1:0]  MAG_SAT_16   = 31'd32767;
    localparam logic [PEAK_W-1:0]  MAG_SAT_32   = 31'h7fffffff;

    // percent = (peak * scale) >> shift, exact for every peak below clamp
    localparam logic [63:0] DIV_24 = 64'd8388608 / 64'd100;
    localparam logic [63:0] DIV_32 = 64'h7fffffff / 64'd100;
    localparam int SHIFT_8  = 7;
    localparam int SHIFT_16 = 15;
    localparam int SHIFT_24 = 41;
    localparam int SHIFT_32 = 56;
    localparam logic [31:0] SCALE_PCT = 32'd100;
    localparam logic [31:0] RECIP_24 =
        32'(((64'd1 << SHIFT_24) + DIV_24 - 64'd1) / DIV_24);
    localparam logic [31:0] RECIP_32 =
        32'(((64'd1 << SHIFT_32) + DIV_32 - 64'd1) / DIV_32);

endpackage

`default_nettype wire

>>> design/audio_peak_level_meter.sv
`default_nettype none

// PCM peak level meter. Takes one sample beat per clock while o_stall is low,
// and keeps a running peak magnitude per channel (stereo alternates left/right
// starting with left). Only the beat flagged last_sample produces a result
// beat, which carries both peaks, their whole-percent levels and the loud
// flag, and the running state clears for the next buffer. The peak compare and
// channel toggle on the input register set the rate; after its last sample is
// taken, the result passes the peak capture, percent multiply, and clamp and
// threshold compare registers, and those stages overlap with later samples.
// Configuration is through the APB port at byte offsets 0x0 width mode,
// 0x4 stereo, 0x8 big endian, 0xC threshold; write it only while idle.
module audio_peak_level_meter (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [plm_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [plm_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [plm_pkg::APB_DATA_W-1:0] prdata,
    output logic                                pready,
    input  wire logic                           i_valid,
    output logic                                o_stall,
    input  wire plm_pkg::t_plm_in               i_data,
    output logic                                o_valid,
    input  wire logic                           i_stall,
    output plm_pkg::t_plm_out                   o_data
);
    import plm_pkg::*;

    t_plm_cfg   cfg;
    logic       peak_valid;
    logic       peak_stall;
    t_plm_peaks peaks;

    plm_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    plm_peak_track u_peak_track (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_data       (i_data),
        .o_peak_valid (peak_valid),
        .i_peak_stall (peak_stall),
        .o_peaks      (peaks)
    );

    plm_level_calc u_level_calc (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_peak_valid (peak_valid),
        .o_peak_stall (peak_stall),
        .i_peaks      (peaks),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_data       (o_data)
    );

`ifndef SYNTHESIS
    // input side backs up only when the result beat is held downstream
    a_stall_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without a blocked result beat");

    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.level_left <= LEVEL_MAX && o_data.level_right <= LEVEL_MAX))
        else $error("level above full scale");

    a_quiet_not_loud: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.level_left == '0) |-> !o_data.loud_event)
        else $error("loud flag raised on a silent left channel");
`endif

endmodule

`default_nettype wire

>>> design/plm_cfg_regs.sv
`default_nettype none

module plm_cfg_regs (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [plm_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [plm_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [plm_pkg::APB_DATA_W-1:0] prdata,
    output logic                                pready,
    output plm_pkg::t_plm_cfg                   o_cfg
);
    import plm_pkg::*;

    t_plm_cfg r_cfg;
    t_reg_idx reg_idx;
    logic     wr_en;

    assign reg_idx = t_reg_idx'(paddr[APB_ADDR_W-1:2]);
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.width_mode <= WIDTH_16;
            r_cfg.stereo     <= 1'b1;
            r_cfg.big_endian <= 1'b0;
            r_cfg.threshold  <= THRESH_RESET;
        end else if (wr_en) begin
            case (reg_idx)
                REG_WIDTH:  r_cfg.width_mode <= t_width_mode'(pwdata[1:0]);
                REG_STEREO: r_cfg.stereo     <= pwdata[0];
                REG_ENDIAN: r_cfg.big_endian <= pwdata[0];
                REG_THRESH: r_cfg.threshold  <= pwdata[LEVEL_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_WIDTH:  prdata = APB_DATA_W'(r_cfg.width_mode);
            REG_STEREO: prdata = APB_DATA_W'(r_cfg.stereo);
            REG_ENDIAN: prdata = APB_DATA_W'(r_cfg.big_endian);
            REG_THRESH: prdata = APB_DATA_W'(r_cfg.threshold);
            default:    prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

>>> design/plm_peak_track.sv
`default_nettype none

module plm_peak_track (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire plm_pkg::t_plm_cfg   i_cfg,
    input  wire logic                i_valid,
    output logic                     o_stall,
    input  wire plm_pkg::t_plm_in    i_data,
    output logic                     o_peak_valid,
    input  wire logic                i_peak_stall,
    output plm_pkg::t_plm_peaks      o_peaks
);
    import plm_pkg::*;

    logic              r_in_valid;
    t_plm_in           r_in;
    logic [PEAK_W-1:0] r_peak_l;
    logic [PEAK_W-1:0] r_peak_r;
    logic              r_toggle;

    logic [7:0]        b0, b1, b2, b3;
    logic [31:0]       sext;
    logic [32:0]       abs_val;
    logic [PEAK_W-1:0] mag;
    logic              to_right;
    logic [PEAK_W-1:0] n_peak_l;
    logic [PEAK_W-1:0] n_peak_r;
    logic              n_toggle;
    logic              leave;

    assign b0 = r_in.sample_word[7:0];
    assign b1 = r_in.sample_word[15:8];
    assign b2 = r_in.sample_word[23:16];
    assign b3 = r_in.sample_word[31:24];

    always_comb begin
        case (i_cfg.width_mode)
            WIDTH_8:  sext = {{24{b0[7]}}, b0};
            WIDTH_16: sext = i_cfg.big_endian ? {{16{b0[7]}}, b0, b1}
                                              : {{16{b1[7]}}, b1, b0};
            WIDTH_24: sext = i_cfg.big_endian ? {{8{b0[7]}}, b0, b1, b2}
                                              : {{8{b2[7]}}, b2, b1, b0};
            WIDTH_32: sext = i_cfg.big_endian ? {b0, b1, b2, b3}
                                              : {b3, b2, b1, b0};
            default:  sext = {b3, b2, b1, b0};
        endcase
    end

    // most negative 16 and 32 bit codes saturate; 8 and 24 stay exact
    always_comb begin
        abs_val = sext[31] ? (33'd0 - {1'b1, sext}) : {1'b0, sext};
        if (i_cfg.width_mode == WIDTH_16 && abs_val > 33'(MAG_SAT_16)) begin
            mag = MAG_SAT_16;
        end else if (i_cfg.width_mode == WIDTH_32 && abs_val > 33'(MAG_SAT_32)) begin
            mag = MAG_SAT_32;
        end else begin
            mag = abs_val[PEAK_W-1:0];
        end
    end

    assign to_right = i_cfg.stereo && r_toggle;
    assign n_peak_l = (!to_right && mag > r_peak_l) ? mag : r_peak_l;
    assign n_peak_r = (to_right && mag > r_peak_r) ? mag : r_peak_r;
    assign n_toggle = i_cfg.stereo ? !r_toggle : 1'b0;

    assign o_peak_valid = r_in_valid && r_in.last_sample;
    assign leave        = r_in_valid && !(r_in.last_sample && i_peak_stall);
    assign o_stall      = r_in_valid && r_in.last_sample && i_peak_stall;
    assign o_peaks      = '{peak_left: n_peak_l, peak_right: n_peak_r};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_peak_l   <= '0;
            r_peak_r   <= '0;
            r_toggle   <= 1'b0;
        end else begin
            if (!o_stall) begin
                r_in_valid <= i_valid;
            end
            if (leave) begin
                if (r_in.last_sample) begin
                    r_peak_l <= '0;
                    r_peak_r <= '0;
                    r_toggle <= 1'b0;
                end else begin
                    r_peak_l <= n_peak_l;
                    r_peak_r <= n_peak_r;
                    r_toggle <= n_toggle;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall) begin
            r_in <= i_data;
        end
    end

endmodule

`default_nettype wire

>>> design/plm_level_calc.sv
`default_nettype none

module plm_level_calc (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire plm_pkg::t_plm_cfg   i_cfg,
    input  wire logic                i_peak_valid,
    output logic                     o_peak_stall,
    input  wire plm_pkg::t_plm_peaks i_peaks,
    output logic                     o_valid,
    input  wire logic                i_stall,
    output plm_pkg::t_plm_out        o_data
);
    import plm_pkg::*;

    logic              r_s1_valid;
    t_plm_peaks        r_s1;
    logic              r_s2_valid;
    t_plm_peaks        r_s2;
    logic [PROD_W-1:0] r_prod_l;
    logic [PROD_W-1:0] r_prod_r;
    logic              r_out_valid;
    t_plm_out          r_out;

    logic              out_adv;
    logic              s2_adv;
    logic              s1_adv;
    logic [31:0]       scale;
    logic [PROD_W-1:0] n_prod_l;
    logic [PROD_W-1:0] n_prod_r;
    logic [LEVEL_W-1:0] pct_l;
    logic [LEVEL_W-1:0] pct_r;
    t_plm_out          n_out;

    function automatic logic [LEVEL_W-1:0] f_percent(input logic [PROD_W-1:0] prod,
                                                     input t_width_mode mode);
        logic [PROD_W-1:0] q;
        begin
            case (mode)
                WIDTH_8:  q = prod >> SHIFT_8;
                WIDTH_16: q = prod >> SHIFT_16;
                WIDTH_24: q = prod >> SHIFT_24;
                WIDTH_32: q = prod >> SHIFT_32;
                default:  q = prod >> SHIFT_32;
            endcase
            if (q > PROD_W'(LEVEL_MAX)) begin
                return LEVEL_MAX;
            end
            return q[LEVEL_W-1:0];
        end
    endfunction

    assign out_adv      = !r_out_valid || !i_stall;
    assign s2_adv       = !r_s2_valid || out_adv;
    assign s1_adv       = !r_s1_valid || s2_adv;
    assign o_peak_stall = !s1_adv;

    always_comb begin
        case (i_cfg.width_mode)
            WIDTH_8:  scale = SCALE_PCT;
            WIDTH_16: scale = SCALE_PCT;
            WIDTH_24: scale = RECIP_24;
            WIDTH_32: scale = RECIP_32;
            default:  scale = RECIP_32;
        endcase
    end

    assign n_prod_l = PROD_W'(r_s1.peak_left) * PROD_W'(scale);
    assign n_prod_r = PROD_W'(r_s1.peak_right) * PROD_W'(scale);

    assign pct_l = f_percent(r_prod_l, i_cfg.width_mode);
    assign pct_r = f_percent(r_prod_r, i_cfg.width_mode);

    always_comb begin
        n_out.level_left  = pct_l;
        n_out.level_right = i_cfg.stereo ? pct_r : '0;
        n_out.peak_left   = r_s2.peak_left;
        n_out.peak_right  = r_s2.peak_right;
        n_out.loud_event  = pct_l > i_cfg.threshold;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_adv) begin
                r_s1_valid <= i_peak_valid;
            end
            if (s2_adv) begin
                r_s2_valid <= r_s1_valid;
            end
            if (out_adv) begin
                r_out_valid <= r_s2_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_s1 <= i_peaks;
        end
        if (s2_adv) begin
            r_s2     <= r_s1;
            r_prod_l <= n_prod_l;
            r_prod_r <= n_prod_r;
        end
        if (out_adv) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

`default_nettype wire
